>>> rtl/imu_pitch_complementary_filter_assert.svh
// Assertion shorthands for the pitch filter checker.
`ifndef IMU_PITCH_COMPLEMENTARY_FILTER_ASSERT_SVH
`define IMU_PITCH_COMPLEMENTARY_FILTER_ASSERT_SVH

// Clocked check, masked while reset is high.
`define IPCF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds across reset.
`define IPCF_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/ipcf_pkg.sv
`default_nettype none
package ipcf_pkg;
   localparam int CORDIC_ITERATIONS = 18;
   localparam int NUM_AXES          = 6;
   localparam int HALF_PI_Q16       = 102944;
   localparam int REQ_W             = 96;
   localparam int RSP_W             = 120;

   localparam logic [1:0] STATUS_CAL   = 2'd0;
   localparam logic [1:0] STATUS_BIAS  = 2'd1;
   localparam logic [1:0] STATUS_PITCH = 2'd2;

   localparam logic [1:0] CSR_CAL_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_ALPHA       = 2'd1;
   localparam logic [1:0] CSR_GYRO_STEP   = 2'd2;

   typedef logic signed [15:0] sample_type;

   // atan(2^-i) in Q24
   function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
      logic signed [27:0] v;
      case (idx)
         5'd0:  v = 28'sd13176795;
         5'd1:  v = 28'sd7778716;
         5'd2:  v = 28'sd4110060;
         5'd3:  v = 28'sd2086331;
         5'd4:  v = 28'sd1047214;
         5'd5:  v = 28'sd524117;
         5'd6:  v = 28'sd262123;
         5'd7:  v = 28'sd131069;
         5'd8:  v = 28'sd65536;
         5'd9:  v = 28'sd32768;
         5'd10: v = 28'sd16384;
         5'd11: v = 28'sd8192;
         5'd12: v = 28'sd4096;
         5'd13: v = 28'sd2048;
         5'd14: v = 28'sd1024;
         5'd15: v = 28'sd512;
         5'd16: v = 28'sd256;
         5'd17: v = 28'sd128;
         5'd18: v = 28'sd64;
         5'd19: v = 28'sd32;
         5'd20: v = 28'sd16;
         5'd21: v = 28'sd8;
         5'd22: v = 28'sd4;
         5'd23: v = 28'sd2;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

>>> rtl/ipcf_div.sv
`default_nettype none
// Signed 32 / unsigned 16 restoring divider, one quotient bit per cycle.
module ipcf_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [15:0]      quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic [16:0] rem_sh;
   logic [17:0] diff;
   logic [31:0] q_signed;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, quo_ff[31]};
      diff    = {1'b0, rem_sh} - {2'b00, divisor};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = 16'd0;
         neg_in  = dividend[31];
         quo_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
      end else if (busy_ff) begin
         if (!diff[17]) begin
            rem_in = diff[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign q_signed = neg_ff ? (~quo_ff + 32'd1) : quo_ff;
   assign quotient = q_signed[15:0];
   assign done     = done_ff;
endmodule
`default_nettype wire

>>> rtl/imu_pitch_complementary_filter.sv
`default_nettype none
// IMU pitch complementary filter.
// req_ channel: one beat per six-axis sample. rsp_ channel: exactly one beat
// per request beat, in order. tuser carries the status code (calibrating,
// biases ready, pitch valid); tdata carries pitch and the six biases.
// csr_ port: write-only, csr_index 0 cal_samples, 1 alpha, 2 gyro_step.
// Write only while idle.
// Per beat, from the accepting cycle until ready again: a calibration beat
// that is not the last goes straight to the done state. The last one runs
// the shared serial divider six times, once per axis. A filter beat runs 18
// CORDIC iterations through one shift-add unit, a round/clamp step, two
// multiply steps and a round/saturate step; CORDIC and round/clamp are
// skipped if dz is zero. rsp_tvalid rises the cycle after the beat finishes.
// One sample is in flight at a time. The result sits in an output register;
// a new beat is taken while it waits. If the receiver stalls, the next
// result holds in its done state and the input stays not ready.
// Reset (synchronous): CSRs, model state and FSM reset; calibration restarts.
module imu_pitch_complementary_filter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // ax, ay, az, gx, gy, gz, 16 bits each from bit 0
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pitch[17:0], bias ax, ay, az, gx, gy, gz (16 each), zero fill
   output logic [119:0]     rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import ipcf_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV_GO   = 4'd1;
   localparam logic [3:0] S_DIV_WAIT = 4'd2;
   localparam logic [3:0] S_CORD     = 4'd3;
   localparam logic [3:0] S_ROUND    = 4'd4;
   localparam logic [3:0] S_MUL1     = 4'd5;
   localparam logic [3:0] S_MUL2     = 4'd6;
   localparam logic [3:0] S_FIN      = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   localparam logic [4:0] LAST_IT = 5'(CORDIC_ITERATIONS - 1);
   localparam logic signed [17:0] HPI = 18'(HALF_PI_Q16);

   // configuration
   logic [15:0] cal_ff, cal_in;
   logic [15:0] alpha_ff, alpha_in;
   logic [31:0] step_ff, step_in;

   // model state
   logic [15:0] count_ff, count_in;
   logic        calib_ff, calib_in;
   logic [31:0] sums_ff [NUM_AXES];
   logic [31:0] sums_in [NUM_AXES];
   logic [15:0] bias_ff [NUM_AXES];
   logic [15:0] bias_in [NUM_AXES];
   logic signed [17:0] prev_ff, prev_in;

   // sequencer and work registers
   logic [3:0]  state_ff, state_in;
   logic [2:0]  axis_ff, axis_in;
   logic [4:0]  it_ff, it_in;
   logic signed [16:0] gy_ff, gy_in;
   logic signed [39:0] x_ff, x_in, y_ff, y_in;
   logic signed [27:0] z_ff, z_in;
   logic signed [17:0] acc_ff, acc_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [51:0] m1_ff, m1_in;
   logic signed [35:0] m2_ff, m2_in;
   logic [1:0]  status_ff, status_in;
   logic signed [17:0] pitch_ff, pitch_in;

   // output register
   logic         rv_ff, rv_in;
   logic [119:0] rd_ff, rd_in;
   logic [1:0]   ru_ff, ru_in;

   // divider hookup
   logic        div_start, div_done;
   logic [15:0] div_q;

   // combinational helpers
   sample_type          smp [NUM_AXES];
   logic [15:0]         need, cnt_next;
   logic signed [16:0]  dz_new, dy_new;
   logic signed [39:0]  xs, ys;
   logic signed [27:0]  z_rnd;
   logic signed [19:0]  z_q16;
   logic signed [49:0]  prod_r;
   logic signed [34:0]  pred;
   logic signed [17:0]  one_m_alpha;
   logic signed [53:0]  m_sum;
   logic signed [29:0]  p_raw;
   logic                accept;

   ipcf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_ff[axis_ff]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign div_start  = (state_ff == S_DIV_GO);

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         smp[k] = req_tdata[16*k +: 16];
      end
      need     = (cal_ff == 16'd0) ? 16'd1 : cal_ff;
      cnt_next = count_ff + 16'd1;
      dy_new   = 17'(smp[1]) - 17'($signed(bias_ff[1]));
      dz_new   = 17'(smp[2]) - 17'($signed(bias_ff[2]));
      xs       = x_ff >>> it_ff;
      ys       = y_ff >>> it_ff;
      z_rnd    = z_ff + 28'sd128;
      z_q16    = z_rnd[27:8];
      prod_r   = prod_ff + 50'sd32768;
      // previous pitch at 24 fraction bits plus the rounded gyro increment
      pred     = {{9{prev_ff[17]}}, prev_ff, 8'd0} + {prod_r[49], prod_r[49:16]};
      one_m_alpha = 18'sd65536 - $signed({2'b00, alpha_ff});
      m_sum    = 54'(m1_ff) + {{10{m2_ff[35]}}, m2_ff, 8'd0};
      p_raw    = 30'(m_sum[53:24] + 30'(m_sum[23]));
   end

   always_comb begin
      cal_in   = cal_ff;
      alpha_in = alpha_ff;
      step_in  = step_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAL_SAMPLES: cal_in   = csr_wdata[15:0];
            CSR_ALPHA:       alpha_in = csr_wdata[15:0];
            CSR_GYRO_STEP:   step_in  = csr_wdata;
            default: ;
         endcase
      end

      count_in  = count_ff;
      calib_in  = calib_ff;
      sums_in   = sums_ff;
      bias_in   = bias_ff;
      prev_in   = prev_ff;
      state_in  = state_ff;
      axis_in   = axis_ff;
      it_in     = it_ff;
      gy_in     = gy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      status_in = status_ff;
      pitch_in  = pitch_ff;
      rv_in     = rv_ff && !rsp_tready;
      rd_in     = rd_ff;
      ru_in     = ru_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!calib_ff) begin
                  for (int k = 0; k < NUM_AXES; k++) begin
                     sums_in[k] = sums_ff[k] + 32'(smp[k]);
                  end
                  count_in = cnt_next;
                  if (cnt_next >= need) begin
                     axis_in  = 3'd0;
                     state_in = S_DIV_GO;
                  end else begin
                     status_in = STATUS_CAL;
                     state_in  = S_DONE;
                  end
               end else begin
                  gy_in = 17'(smp[4]) - 17'($signed(bias_ff[4]));
                  if (dz_new == 17'sd0) begin
                     acc_in   = (dy_new > 0) ? HPI : ((dy_new < 0) ? -HPI : 18'sd0);
                     state_in = S_MUL1;
                  end else begin
                     it_in    = 5'd0;
                     z_in     = 28'sd0;
                     state_in = S_CORD;
                     x_in     = {7'd0, (dz_new[16] ? -dz_new : dz_new), 16'd0};
                     y_in     = 40'(dz_new[16] ? -dy_new : dy_new) <<< 16;
                  end
               end
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_done) begin
               bias_in[axis_ff] = div_q;
               if (axis_ff == 3'(NUM_AXES - 1)) begin
                  calib_in  = 1'b1;
                  status_in = STATUS_BIAS;
                  state_in  = S_DONE;
               end else begin
                  axis_in  = axis_ff + 3'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_CORD: begin
            if (!y_ff[39]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_q24(it_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_q24(it_ff);
            end
            it_in = it_ff + 5'd1;
            if (it_ff == LAST_IT) state_in = S_ROUND;
         end
         S_ROUND: begin
            if (z_q16 > 20'(HPI)) acc_in = HPI;
            else if (z_q16 < -20'(HPI)) acc_in = -HPI;
            else acc_in = z_q16[17:0];
            state_in = S_MUL1;
         end
         S_MUL1: begin
            prod_in  = gy_ff * $signed({1'b0, step_ff});
            state_in = S_MUL2;
         end
         S_MUL2: begin
            m1_in    = $signed({1'b0, alpha_ff}) * pred;
            m2_in    = one_m_alpha * acc_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (p_raw > 30'sd131071) pitch_in = 18'sd131071;
            else if (p_raw < -30'sd131072) pitch_in = -18'sd131072;
            else pitch_in = p_raw[17:0];
            prev_in   = pitch_in;
            status_in = STATUS_PITCH;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               ru_in = status_ff;
               rd_in = 120'd0;
               if (status_ff == STATUS_PITCH) rd_in[17:0] = pitch_ff;
               if (status_ff == STATUS_BIAS) begin
                  for (int k = 0; k < NUM_AXES; k++) begin
                     rd_in[18 + 16*k +: 16] = bias_ff[k];
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff   <= 16'd100;
         alpha_ff <= 16'd65472;
         step_ff  <= 32'd585072;
         count_ff <= 16'd0;
         calib_ff <= 1'b0;
         for (int k = 0; k < NUM_AXES; k++) begin
            sums_ff[k] <= 32'd0;
            bias_ff[k] <= 16'd0;
         end
         prev_ff  <= 18'sd0;
         state_ff <= S_IDLE;
         axis_ff  <= 3'd0;
         rv_ff    <= 1'b0;
      end else begin
         cal_ff   <= cal_in;
         alpha_ff <= alpha_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         calib_ff <= calib_in;
         sums_ff  <= sums_in;
         bias_ff  <= bias_in;
         prev_ff  <= prev_in;
         state_ff <= state_in;
         axis_ff  <= axis_in;
         rv_ff    <= rv_in;
      end
      it_ff     <= it_in;
      gy_ff     <= gy_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      status_ff <= status_in;
      pitch_ff  <= pitch_in;
      rd_ff     <= rd_in;
      ru_ff     <= ru_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;
endmodule
`default_nettype wire

>>> rtl/ipcf_checker.sv
`default_nettype none
`include "imu_pitch_complementary_filter_assert.svh"
module ipcf_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [119:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);
   import ipcf_pkg::*;

   logic [17:0]  pitch_field;
   logic [101:0] bias_field;
   logic         not_pitch, not_bias, stalled;

   assign pitch_field = rsp_tdata[17:0];
   assign bias_field  = rsp_tdata[119:18];
   assign not_pitch   = rsp_tvalid && (rsp_tuser != STATUS_PITCH);
   assign not_bias    = rsp_tvalid && (rsp_tuser != STATUS_BIAS);
   assign stalled     = rsp_tvalid && !rsp_tready;

   `IPCF_ASSERT_NR(a_rst_quiet, reset |=> !rsp_tvalid, "rsp valid after reset")
   `IPCF_ASSERT(a_pitch_zero, not_pitch |-> (pitch_field == '0), "pitch outside pitch beat")
   `IPCF_ASSERT(a_bias_zero, not_bias |-> (bias_field == '0), "bias outside bias beat")
   `IPCF_ASSERT(a_hold, stalled |=> (rsp_tvalid && $stable({rsp_tuser, rsp_tdata})), "beat changed")
endmodule

bind imu_pitch_complementary_filter ipcf_checker u_ipcf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
